// ----- sv/gnsc_pkg.sv -----
// ----------------------------------------------------------------------------
// gnsc_pkg
// Types, register indexes, codes and neighbor offsets of the grid neighbor
// state census unit.
// ----------------------------------------------------------------------------
package gnsc_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int SIZE_W     = 7;
    localparam int COORD_W    = 6;
    localparam int STATE_W    = 2;
    localparam int COUNT_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOORE_MODE  = 2'd2;

    localparam logic [SIZE_W-1:0] RST_GRID_WIDTH  = 7'd64;
    localparam logic [SIZE_W-1:0] RST_GRID_HEIGHT = 7'd64;
    localparam logic              RST_MOORE_MODE  = 1'b1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [STATE_W-1:0] ST_CONIFER      = 2'd0;
    localparam logic [STATE_W-1:0] ST_DECIDUOUS    = 2'd1;
    localparam logic [STATE_W-1:0] ST_MIXED        = 2'd2;
    localparam logic [STATE_W-1:0] ST_TRANSITIONAL = 2'd3;

    localparam int NB_MOORE = 8;
    localparam int NB_VN    = 4;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [STATE_W-1:0] cell_state;
    } gnsc_cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] conifer_count;
        logic [COUNT_W-1:0] deciduous_count;
        logic [COUNT_W-1:0] mixed_count;
        logic [COUNT_W-1:0] transitional_count;
        logic [COUNT_W-1:0] inside_count;
        logic               coord_error;
    } gnsc_result_t;

    // column offset of neighbor k: first four are von Neumann
    function automatic logic signed [1:0] nb_dc(input logic [2:0] k);
        case (k)
            3'd0:    nb_dc = 2'sd0;
            3'd1:    nb_dc = 2'sd0;
            3'd2:    nb_dc = 2'sd1;
            3'd3:    nb_dc = -2'sd1;
            3'd4:    nb_dc = -2'sd1;
            3'd5:    nb_dc = -2'sd1;
            3'd6:    nb_dc = 2'sd1;
            3'd7:    nb_dc = 2'sd1;
            default: nb_dc = 2'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] nb_dr(input logic [2:0] k);
        case (k)
            3'd0:    nb_dr = -2'sd1;
            3'd1:    nb_dr = 2'sd1;
            3'd2:    nb_dr = 2'sd0;
            3'd3:    nb_dr = 2'sd0;
            3'd4:    nb_dr = 2'sd1;
            3'd5:    nb_dr = -2'sd1;
            3'd6:    nb_dr = 2'sd1;
            3'd7:    nb_dr = -2'sd1;
            default: nb_dr = 2'sd0;
        endcase
    endfunction

endpackage

// ----- sv/grid_neighbor_state_census_unit.sv -----
// ----------------------------------------------------------------------------
// grid_neighbor_state_census_unit
// Two-bit cell state grid with a neighbor state census on query.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken at a rising edge with start high and
//   busy low. A write beat stores cell_state at width*row+col in the same
//   cycle and leaves busy low; it gives no result. A query beat raises busy.
//   The query steps one neighbor per cycle through the shared address
//   multiplier and the single grid RAM port over 4 or 8 neighbors, then a
//   drain state for the last read, then done is high for exactly one cycle
//   with the result, and the next command is taken the cycle after done.
//   A query outside the grid goes from accept straight to done.
//   The receiver cannot stall: the result beat is on the ports for one
//   cycle only.
//   Config channel: cfg_ready is always high; write only while idle.
//   Reset: registers return to 64 x 64, Moore mode; the grid RAM is not
//   cleared and must be written before it is read.
// ----------------------------------------------------------------------------
module grid_neighbor_state_census_unit #(
    parameter int MAX_WIDTH  = gnsc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gnsc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  gnsc_pkg::gnsc_cmd_t                cmd,
    output logic                               done,
    output gnsc_pkg::gnsc_result_t             result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gnsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gnsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import gnsc_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW0   = (WW > SIZE_W) ? WW : SIZE_W;
    localparam int CW    = (HW > CW0) ? HW : CW0;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]  grid_width_reg, grid_height_reg;
    logic               moore_mode_reg;
    logic [COORD_W-1:0] col_reg, row_reg;
    logic [2:0]         k_reg, k_next;
    logic               pend_reg, pend_next;
    logic               err_reg, err_next;
    logic [COUNT_W-1:0] cnt_reg [4];
    logic [COUNT_W-1:0] cnt_next [4];
    logic [COUNT_W-1:0] inside_reg, inside_next;

    logic [CW-1:0]       eff_w, eff_h, gw_ext, gh_ext;
    logic                in_outside;
    logic signed [7:0]   nc, nr;
    logic                nb_inside;
    logic [SIZE_W-1:0]   sel_col, sel_row;
    logic [2*CW-1:0]     prod;
    logic [AW-1:0]       ram_addr;
    logic                ram_en, ram_we;
    logic [STATE_W-1:0]  ram_rdata;
    logic                accept;
    logic [2:0]          k_last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= RST_GRID_WIDTH;
            grid_height_reg <= RST_GRID_HEIGHT;
            moore_mode_reg  <= RST_MOORE_MODE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                REG_MOORE_MODE:  moore_mode_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // effective grid size: zero acts as one, clamp to maximum
    always_comb
    begin
        gw_ext = CW'(grid_width_reg);
        gh_ext = CW'(grid_height_reg);
        if (gw_ext == '0)
            eff_w = CW'(1);
        else if (gw_ext > CW'(MAX_WIDTH))
            eff_w = CW'(MAX_WIDTH);
        else
            eff_w = gw_ext;
        if (gh_ext == '0)
            eff_h = CW'(1);
        else if (gh_ext > CW'(MAX_HEIGHT))
            eff_h = CW'(MAX_HEIGHT);
        else
            eff_h = gh_ext;
    end

    assign in_outside = (CW'(cmd.col) >= eff_w) || (CW'(cmd.row) >= eff_h);
    assign accept     = start && !busy;

    always_comb
    begin
        nc = $signed({2'b00, col_reg}) + 8'(nb_dc(k_reg));
        nr = $signed({2'b00, row_reg}) + 8'(nb_dr(k_reg));
        nb_inside = !nc[7] && !nr[7]
                    && (CW'(nc[SIZE_W-1:0]) < eff_w)
                    && (CW'(nr[SIZE_W-1:0]) < eff_h);
    end

    // shared address multiplier: command coordinate when idle, neighbor in scan
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            sel_col = {1'b0, cmd.col};
            sel_row = {1'b0, cmd.row};
        end
        else
        begin
            sel_col = nc[SIZE_W-1:0];
            sel_row = nr[SIZE_W-1:0];
        end
        prod     = eff_w * CW'(sel_row);
        ram_addr = AW'(prod + (2*CW)'(sel_col));
    end

    assign ram_we = (state_reg == S_IDLE) && accept && (cmd.action == ACT_WRITE)
                    && !in_outside;
    assign ram_en = ram_we || ((state_reg == S_SCAN) && nb_inside);

    gnsc_ram #(
        .WIDTH (STATE_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cmd.cell_state),
        .rdata (ram_rdata)
    );

    assign k_last = moore_mode_reg ? 3'(NB_MOORE - 1) : 3'(NB_VN - 1);

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        pend_next   = 1'b0;
        err_next    = err_reg;
        cnt_next    = cnt_reg;
        inside_next = inside_reg;

        if (pend_reg)
        begin
            cnt_next[ram_rdata] = cnt_reg[ram_rdata] + COUNT_W'(1);
            inside_next         = inside_reg + COUNT_W'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.action == ACT_QUERY))
                begin
                    k_next      = '0;
                    err_next    = in_outside;
                    inside_next = '0;
                    for (int i = 0; i < 4; i++)
                        cnt_next[i] = '0;
                    state_next  = in_outside ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                pend_next = nb_inside;
                k_next    = k_reg + 3'd1;
                if (k_reg == k_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (cmd.action == ACT_QUERY))
        begin
            col_reg <= cmd.col;
            row_reg <= cmd.row;
        end
        err_reg    <= err_next;
        cnt_reg    <= cnt_next;
        inside_reg <= inside_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        result.conifer_count      = cnt_reg[ST_CONIFER];
        result.deciduous_count    = cnt_reg[ST_DECIDUOUS];
        result.mixed_count        = cnt_reg[ST_MIXED];
        result.transitional_count = cnt_reg[ST_TRANSITIONAL];
        result.inside_count       = inside_reg;
        result.coord_error        = err_reg;
    end

endmodule

// ----- sv/gnsc_ram.sv -----
// ----------------------------------------------------------------------------
// gnsc_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module gnsc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
